[rtl/lss_pkg.sv]
// Shared types and constants for the least-squares slope block.
package lss_pkg;

   // Fixed widths of the channel fields.
   localparam int COORD_W  = 16;
   localparam int SLOPE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POINTS_W = 11;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FLAT = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   // Sequencer states of the fitting engine.
   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_PREP,
      BACK_DIV,
      BACK_FIN
   } back_state_type;

endpackage

[rtl/lss_intf.sv]
// Valid/ready channel interfaces for points and slope results.
interface lss_req_if import lss_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  x_mm;
   logic signed [COORD_W-1:0]  y_mm;
   logic                       last;

   modport source (output valid, x_mm, y_mm, last, input ready);
   modport sink (input valid, x_mm, y_mm, last, output ready);
endinterface

interface lss_rsp_if import lss_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SLOPE_W-1:0]  slope_q16;
   logic [STATUS_W-1:0]        status;
   logic [POINTS_W-1:0]        points_used;

   modport source (output valid, slope_q16, status, points_used, input ready);
   modport sink (input valid, slope_q16, status, points_used, output ready);
endinterface

[rtl/lss_front.sv]
// Point intake: coordinate products and sums, one point per cycle unless a last point waits.
module lss_front import lss_pkg::*; #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16,
   parameter int CB         = 11,
   parameter int SW         = 27,
   parameter int PW         = 43
) (
   input  logic                   clock,
   input  logic                   reset,
   lss_req_if.sink                req,
   output logic                   push,
   output logic [CB+2*SW+2*PW-1:0] push_data,
   input  logic                   full
);

   localparam int XW = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;

   logic [XW-1:0]                 x_zext;
   logic [XW-1:0]                 y_zext;
   logic signed [COORD_BITS-1:0]  x_sel;
   logic signed [COORD_BITS-1:0]  y_sel;
   logic signed [2*COORD_BITS-1:0] xx_prod;
   logic signed [2*COORD_BITS-1:0] xy_prod;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_last_ff;
   logic signed [COORD_BITS-1:0]  x_ff, y_ff;
   logic signed [2*COORD_BITS-1:0] xx_ff, xy_ff;

   logic [CB-1:0]                 cnt_ff, cnt_in;
   logic [SW-1:0]                 sx_ff, sx_in, sy_ff, sy_in;
   logic [PW-1:0]                 sxx_ff, sxx_in, sxy_ff, sxy_in;
   logic                          take;
   logic                          advance;
   logic                          accept;

   // Only the low COORD_BITS bits of each coordinate count, sign at their top bit.
   always_comb begin
      x_zext  = XW'($unsigned(req.x_mm));
      y_zext  = XW'($unsigned(req.y_mm));
      x_sel   = $signed(x_zext[COORD_BITS-1:0]);
      y_sel   = $signed(y_zext[COORD_BITS-1:0]);
      xx_prod = x_sel * x_sel;
      xy_prod = x_sel * y_sel;
   end

   // A last point holds the product stage until the queue has room.
   assign advance   = s1_valid_ff && !(s1_last_ff && full);
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;
   assign push      = s1_valid_ff && s1_last_ff && !full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Product stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= req.last;
         x_ff       <= x_sel;
         y_ff       <= y_sel;
         xx_ff      <= xx_prod;
         xy_ff      <= xy_prod;
      end
   end

   // Accumulation; points beyond MAX_POINTS are dropped but a last flag still closes the set.
   always_comb begin
      take   = cnt_ff < CB'(MAX_POINTS);
      cnt_in = cnt_ff + CB'(take);
      sx_in  = sx_ff + (take ? SW'(x_ff) : '0);
      sy_in  = sy_ff + (take ? SW'(y_ff) : '0);
      sxx_in = sxx_ff + (take ? PW'(xx_ff) : '0);
      sxy_in = sxy_ff + (take ? PW'(xy_ff) : '0);
   end

   assign push_data = {cnt_in, sx_in, sy_in, sxx_in, sxy_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxx_ff <= '0;
         sxy_ff <= '0;
      end else if (advance) begin
         if (s1_last_ff) begin
            cnt_ff <= '0;
            sx_ff  <= '0;
            sy_ff  <= '0;
            sxx_ff <= '0;
            sxy_ff <= '0;
         end else begin
            cnt_ff <= cnt_in;
            sx_ff  <= sx_in;
            sy_ff  <= sy_in;
            sxx_ff <= sxx_in;
            sxy_ff <= sxy_in;
         end
      end
   end

endmodule

[rtl/lss_fifo.sv]
// Two-entry queue of finished set sums between intake and fitting engine.
module lss_fifo #(
   parameter int WIDTH = 151
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             nonempty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign full     = fill_ff == 2'd2;
   assign nonempty = fill_ff != 2'd0;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/lss_back.sv]
// Fitting engine: shift-add products, restoring divide, saturation and result register.
module lss_back import lss_pkg::*; #(
   parameter int CB        = 11,
   parameter int SW        = 27,
   parameter int PW        = 43,
   parameter int NW        = 54,
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CB+2*SW+2*PW-1:0] set_data,
   input  logic                    set_valid,
   output logic                    set_pop,
   lss_rsp_if.source               rsp
);

   localparam int DW  = NW + FRAC_BITS;
   localparam int CTW = $clog2(DW);
   localparam int QW  = (DW > SLOPE_W + 1) ? DW : SLOPE_W + 1;
   localparam int PXW = (CB > POINTS_W) ? CB : POINTS_W;

   back_state_type state_ff, state_in;

   logic [CB-1:0]   set_n;
   logic [SW-1:0]   set_sx, set_sy;
   logic [PW-1:0]   set_sxx, set_sxy;

   logic [CTW-1:0]  cnt_ff, cnt_in;
   logic [CB-1:0]   n_ff, n_in;
   logic [SW-1:0]   n_sr_ff, n_sr_in, sx_sr_ff, sx_sr_in;
   logic [NW-1:0]   sxy_sh_ff, sxy_sh_in, sy_sh_ff, sy_sh_in;
   logic [NW-1:0]   sxx_sh_ff, sxx_sh_in, sx_sh_ff, sx_sh_in;
   logic [NW-1:0]   num_ff, num_in, den_ff, den_in;
   logic            neg_ff, neg_in, flat_ff, flat_in;
   logic [DW-1:0]   dvd_ff, dvd_in;
   logic [NW:0]     rem_ff, rem_in;

   logic                      out_valid_ff, out_valid_in;
   logic signed [SLOPE_W-1:0] out_slope_ff, out_slope_in;
   logic [STATUS_W-1:0]       out_status_ff, out_status_in;
   logic [POINTS_W-1:0]       out_points_ff, out_points_in;

   logic            mul_last, div_last, out_free;
   logic [NW-1:0]   part_num, part_den, term_num, term_den, num_mag;
   logic [NW:0]     rem_shift;
   logic [NW+1:0]   rem_diff;
   logic            rem_ge;
   logic [QW-1:0]   quot, limit;
   logic            sat;
   logic [SLOPE_W-1:0] mag_sat;
   logic [PXW-1:0]  points_ext;

   // Queue entry layout, most significant first: count, Sx, Sy, Sxx, Sxy.
   assign set_n   = set_data[CB+2*SW+2*PW-1 -: CB];
   assign set_sx  = set_data[2*SW+2*PW-1 -: SW];
   assign set_sy  = set_data[SW+2*PW-1 -: SW];
   assign set_sxx = set_data[2*PW-1 -: PW];
   assign set_sxy = set_data[PW-1:0];

   // Shared arithmetic of the multiply, divide and finish steps.
   always_comb begin
      mul_last  = cnt_ff == CTW'(SW - 1);
      div_last  = cnt_ff == CTW'(DW - 1);
      out_free  = !out_valid_ff || rsp.ready;
      part_num  = n_sr_ff[0] ? sxy_sh_ff : '0;
      part_den  = n_sr_ff[0] ? sxx_sh_ff : '0;
      term_num  = sx_sr_ff[0] ? sy_sh_ff : '0;
      term_den  = sx_sr_ff[0] ? sx_sh_ff : '0;
      num_mag   = num_ff[NW-1] ? (~num_ff + NW'(1)) : num_ff;
      rem_shift = {rem_ff[NW-1:0], dvd_ff[DW-1]};
      rem_diff  = {1'b0, rem_shift} - {2'b00, den_ff};
      rem_ge    = !rem_diff[NW+1];
      quot      = QW'(dvd_ff);
      limit     = neg_ff ? (QW'(1) << (SLOPE_W - 1))
                         : ((QW'(1) << (SLOPE_W - 1)) - QW'(1));
      sat       = quot > limit;
      mag_sat   = sat ? limit[SLOPE_W-1:0] : quot[SLOPE_W-1:0];
      points_ext = PXW'(n_ff);
   end

   // Sequencer: next state, datapath steps and result load.
   always_comb begin
      state_in      = state_ff;
      set_pop       = 1'b0;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      n_sr_in       = n_sr_ff;
      sx_sr_in      = sx_sr_ff;
      sxy_sh_in     = sxy_sh_ff;
      sy_sh_in      = sy_sh_ff;
      sxx_sh_in     = sxx_sh_ff;
      sx_sh_in      = sx_sh_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      flat_in       = flat_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_slope_in  = out_slope_ff;
      out_status_in = out_status_ff;
      out_points_in = out_points_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (set_valid) begin
               set_pop   = 1'b1;
               n_in      = set_n;
               n_sr_in   = SW'(set_n);
               sx_sr_in  = set_sx;
               sxy_sh_in = NW'($signed(set_sxy));
               sy_sh_in  = NW'($signed(set_sy));
               sxx_sh_in = NW'($signed(set_sxx));
               sx_sh_in  = NW'($signed(set_sx));
               num_in    = '0;
               den_in    = '0;
               cnt_in    = '0;
               state_in  = BACK_MUL;
            end
         end
         BACK_MUL: begin
            // n * S?? minus Sx * S?, one multiplier bit a cycle; the top Sx bit weighs negative.
            if (mul_last) begin
               num_in = num_ff + part_num + term_num;
               den_in = den_ff + part_den + term_den;
               state_in = BACK_PREP;
            end else begin
               num_in = num_ff + part_num - term_num;
               den_in = den_ff + part_den - term_den;
            end
            n_sr_in   = n_sr_ff >> 1;
            sx_sr_in  = sx_sr_ff >> 1;
            sxy_sh_in = sxy_sh_ff << 1;
            sy_sh_in  = sy_sh_ff << 1;
            sxx_sh_in = sxx_sh_ff << 1;
            sx_sh_in  = sx_sh_ff << 1;
            cnt_in    = cnt_ff + CTW'(1);
         end
         BACK_PREP: begin
            // A zero x spread skips the divide.
            flat_in = den_ff == '0;
            neg_in  = num_ff[NW-1];
            dvd_in  = {num_mag, FRAC_BITS'(0)};
            rem_in  = '0;
            cnt_in  = '0;
            state_in = (den_ff == '0) ? BACK_FIN : BACK_DIV;
         end
         BACK_DIV: begin
            // Restoring division, one quotient bit a cycle shifted into the dividend register.
            rem_in = rem_ge ? rem_diff[NW:0] : rem_shift;
            dvd_in = {dvd_ff[DW-2:0], rem_ge};
            cnt_in = cnt_ff + CTW'(1);
            if (div_last) begin
               state_in = BACK_FIN;
            end
         end
         BACK_FIN: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_points_in = points_ext[POINTS_W-1:0];
               if (flat_ff) begin
                  out_slope_in  = '0;
                  out_status_in = STATUS_FLAT;
               end else begin
                  out_slope_in  = neg_ff ? $signed(~mag_sat + SLOPE_W'(1)) : $signed(mag_sat);
                  out_status_in = sat ? STATUS_SAT : STATUS_OK;
               end
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      n_ff          <= n_in;
      n_sr_ff       <= n_sr_in;
      sx_sr_ff      <= sx_sr_in;
      sxy_sh_ff     <= sxy_sh_in;
      sy_sh_ff      <= sy_sh_in;
      sxx_sh_ff     <= sxx_sh_in;
      sx_sh_ff      <= sx_sh_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      flat_ff       <= flat_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      out_slope_ff  <= out_slope_in;
      out_status_ff <= out_status_in;
      out_points_ff <= out_points_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.slope_q16   = out_slope_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.points_used = out_points_ff;

endmodule

[rtl/least_squares_slope.sv]
// Top level of the least-squares line slope block: intake, set queue and fitting engine.
//
//   channel   dir   beat carries                        accepted when
//   req_ch    in    x_mm, y_mm, last                    req_ch.valid && req_ch.ready
//   rsp_ch    out   slope_q16, status, points_used      rsp_ch.valid && rsp_ch.ready
//
// Points are taken one per cycle; a beat with last waits only while both queue
// entries hold finished sets. Each set then passes through the fitting engine's
// bit-serial multiply over the SW = COORD_BITS + CB bits of Sx and its restoring
// divide over DW = NW + FRAC_BITS quotient bits. A set with zero x spread skips
// the divide. A stalled result holds the engine only at its final step.
// Reset is synchronous and clears the intake sums, the queue and the sequencer.
module least_squares_slope import lss_pkg::*; #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic     clock,
   input  logic     reset,
   lss_req_if.sink  req_ch,
   lss_rsp_if.source rsp_ch
);

   localparam int CB = $clog2(MAX_POINTS + 1);
   localparam int SW = COORD_BITS + CB;
   localparam int PW = 2 * COORD_BITS + CB;
   localparam int NW = 2 * COORD_BITS + 2 * CB;
   localparam int EW = CB + 2 * SW + 2 * PW;

   logic          fifo_push;
   logic [EW-1:0] fifo_push_data;
   logic          fifo_full;
   logic          fifo_pop;
   logic [EW-1:0] fifo_pop_data;
   logic          fifo_nonempty;

   lss_front #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS),
      .CB         (CB),
      .SW         (SW),
      .PW         (PW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .push      (fifo_push),
      .push_data (fifo_push_data),
      .full      (fifo_full)
   );

   lss_fifo #(
      .WIDTH (EW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_push_data),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_pop_data),
      .nonempty  (fifo_nonempty)
   );

   lss_back #(
      .CB        (CB),
      .SW        (SW),
      .PW        (PW),
      .NW        (NW),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .set_data  (fifo_pop_data),
      .set_valid (fifo_nonempty),
      .set_pop   (fifo_pop),
      .rsp       (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   // The intake never pushes a set into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_full)
      else $error("set pushed into full queue");

   // The engine never pops an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> fifo_nonempty)
      else $error("set popped from empty queue");

   // A zero x spread always reports a zero slope.
   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_FLAT) |-> rsp_ch.slope_q16 == '0)
      else $error("flat set with nonzero slope");

   // A saturated slope sits at one of the two limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_SAT) |->
      (rsp_ch.slope_q16 == {1'b0, {(SLOPE_W-1){1'b1}}} ||
       rsp_ch.slope_q16 == {1'b1, {(SLOPE_W-1){1'b0}}}))
      else $error("saturated slope off its limit");
`endif

endmodule
